/* hw/rtl/kab_pkg.sv */
// Shared types, constants and helpers for the angle/bias Kalman filter.
package kab_pkg;

  localparam int WordW   = 32;
  localparam int DtW     = 24;
  localparam int NoiseW  = 31;
  localparam int FullW   = 48;
  localparam int CfgIdxW = 2;
  localparam int DivCntW = 5;

  localparam logic [NoiseW-1:0] AngleNoiseRst   = 31'd268435;
  localparam logic [NoiseW-1:0] BiasNoiseRst    = 31'd805306;
  localparam logic [NoiseW-1:0] MeasureNoiseRst = 31'd8053063;

  localparam logic signed [FullW-1:0] SatMax = 48'sh0000_7FFF_FFFF;
  localparam logic signed [FullW-1:0] SatMin = 48'shFFFF_8000_0000;
  localparam logic signed [WordW-1:0] WordMax = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] WordMin = 32'sh8000_0000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_ADD, ST_DSTART, ST_DWAIT, ST_OUT
  } kab_state_t;

  // Multiply-accumulate steps, in issue order
  typedef enum logic [3:0] {
    OP_ANGLE_PRED = 4'd0,
    OP_DT_BB      = 4'd1,
    OP_P11        = 4'd2,
    OP_P00        = 4'd3,
    OP_ANGLE_CORR = 4'd4,
    OP_BIAS_CORR  = 4'd5,
    OP_COV_AA     = 4'd6,
    OP_COV_AB     = 4'd7,
    OP_COV_BA     = 4'd8,
    OP_COV_BB     = 4'd9
  } kab_op_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANGLE_NOISE   = 2'd0,
    CFG_BIAS_NOISE    = 2'd1,
    CFG_MEASURE_NOISE = 2'd2
  } kab_cfg_idx_t;

  // Control to the shared multiply-accumulate unit
  typedef struct packed {
    logic load;    // register a new product
    logic frac28;  // round off 28 fraction bits, else 16
    logic neg;     // subtract the rounded product
  } kab_mac_ctl_t;

  function automatic logic signed [WordW-1:0] sat32(input logic signed [FullW-1:0] v);
    logic signed [WordW-1:0] r;
    if (v > SatMax) r = WordMax;
    else if (v < SatMin) r = WordMin;
    else r = v[WordW-1:0];
    return r;
  endfunction

endpackage

/* hw/rtl/kab_if.sv */
// Valid/ready channel interfaces for filter input samples and results.
interface kab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] measured_angle;
  logic [31:0] gyro_rate;
  logic [23:0] time_step;

  modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
  modport sink (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] filtered_angle;
  logic [31:0] rate_bias;

  modport source (output valid, filtered_angle, rate_bias, input ready);
  modport sink (input valid, filtered_angle, rate_bias, output ready);
endinterface

/* hw/rtl/kab_mac.sv */
// Shared multiply unit: registered product, then round, accumulate and saturate.
module kab_mac import kab_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kab_mac_ctl_t             ctl,
  input  logic signed [WordW-1:0]  op_a,
  input  logic signed [WordW:0]    op_b,
  input  logic signed [WordW-1:0]  addend,
  output logic signed [FullW-1:0]  sum_full,
  output logic signed [WordW-1:0]  sum_sat
);

  localparam int ProdW = 2 * WordW + 1;

  logic signed [ProdW-1:0] prod_r;
  logic                    frac28_r;
  logic                    neg_r;
  logic signed [ProdW-1:0] half;
  logic signed [ProdW-1:0] rnd_sum;
  logic signed [ProdW-1:0] shifted;
  logic signed [FullW-1:0] rnd;
  logic signed [FullW-1:0] term;

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= ProdW'(op_a) * ProdW'(op_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac28_r <= 1'b0;
      neg_r    <= 1'b0;
    end else if (ctl.load) begin
      frac28_r <= ctl.frac28;
      neg_r    <= ctl.neg;
    end
  end

  // round half up, then accumulate
  always_comb begin
    half     = frac28_r ? (ProdW'(1) <<< 27) : (ProdW'(1) <<< 15);
    rnd_sum  = prod_r + half;
    shifted  = frac28_r ? (rnd_sum >>> 28) : (rnd_sum >>> 16);
    rnd      = shifted[FullW-1:0];
    term     = neg_r ? -rnd : rnd;
    sum_full = FullW'(addend) + term;
    sum_sat  = sat32(sum_full);
  end

endmodule

/* hw/rtl/kab_div.sv */
// Radix-2 restoring divider for the gains: sat32((num * 2^28) / den), toward zero.
module kab_div import kab_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [WordW-1:0] num,
  input  logic signed [WordW:0]   den,
  output logic                    done,
  output logic signed [WordW-1:0] quo
);

  logic               busy_r;
  logic               done_r;
  logic [DivCntW-1:0] cnt_r;
  logic [WordW:0]     rem_r;
  logic [WordW:0]     d_r;
  logic [WordW-1:0]   bits_r;
  logic [WordW-1:0]   q_r;
  logic               neg_r;
  logic signed [WordW-1:0] quo_r;

  logic [WordW-1:0]   mag_n;
  logic [WordW:0]     mag_d;
  logic [59:0]        n_full;
  logic               ovf;
  logic [WordW+1:0]   trial;
  logic               ge;
  logic [WordW:0]     rem_step;
  logic [WordW-1:0]   q_step;

  // operand magnitudes and overflow check at start
  always_comb begin
    mag_n  = num[WordW-1] ? WordW'(-num) : WordW'(num);
    mag_d  = den[WordW] ? (WordW+1)'(-den) : (WordW+1)'(den);
    n_full = {mag_n, 28'd0};
    ovf    = {5'd0, n_full} >= {mag_d, 32'd0};
  end

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, bits_r[WordW-1]};
    ge       = trial >= {1'b0, d_r};
    rem_step = ge ? (WordW+1)'(trial - {1'b0, d_r}) : trial[WordW:0];
    q_step   = {q_r[WordW-2:0], ge};
  end

  function automatic logic signed [WordW-1:0] apply_sign(input logic [WordW-1:0] q,
                                                          input logic neg);
    logic signed [WordW-1:0] r;
    if (neg) begin
      r = (q > 32'h8000_0000) ? WordMin : WordW'(-q);
    end else begin
      r = q[WordW-1] ? WordMax : q;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= num[WordW-1] ^ den[WordW];
        if (mag_d == '0) begin
          // zero divisor: gain is zero
          quo_r  <= '0;
          done_r <= 1'b1;
        end else if (ovf) begin
          quo_r  <= (num[WordW-1] ^ den[WordW]) ? WordMin : WordMax;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= DivCntW'(WordW - 1);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= apply_sign(q_step, neg_r);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= mag_d;
      rem_r  <= {5'd0, n_full[59:32]};
      bits_r <= n_full[31:0];
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_step;
      bits_r <= {bits_r[WordW-2:0], 1'b0};
      q_r    <= q_step;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/kalman_angle_bias_filter.sv */
// Top level: two-state angle/bias Kalman filter with a shared multiplier and divider.
//
// Usage:
//   in_ch carries one IMU sample per beat (measured angle and gyro rate in
//   Q16.16, time step in unsigned Q8.16). out_ch returns one beat per sample
//   with the new angle and gyro bias estimates, Q16.16, saturated.
//   cfg_we/cfg_index/cfg_data write the three noise registers (Q3.28); write
//   them only while no sample is in flight. Indexes beyond the list are ignored.
// Timing:
//   Ten multiply-accumulate steps go through one 32x33 multiplier, and the
//   two gains come from one radix-2 divider that produces a quotient bit
//   per cycle. One sample is in flight at a time; in_ch.ready is high only
//   when idle, so a new sample is taken only after the result beat of the
//   last one is taken.
// Reset:
//   rst_n (synchronous) zeroes the estimates and covariance and loads the
//   default noise values. A stalled out_ch holds its beat and keeps the
//   block busy until the result is taken.
module kalman_angle_bias_filter import kab_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  kab_in_if.sink              in_ch,
  kab_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [NoiseW-1:0]   cfg_data
);

  kab_state_t state_r, state_nxt;
  kab_op_t    op_r, op_nxt;
  logic       ksel_r, ksel_nxt;

  logic [NoiseW-1:0] an_r, bn_r, mn_r;
  logic signed [WordW-1:0] angle_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [WordW-1:0] meas_r, gyro_r;
  logic [DtW-1:0]          dt_r;
  logic signed [WordW-1:0] p00_r, p01_r, p10_r, p11_r, inner_r, y_r, k0_r, k1_r;
  logic signed [FullW-1:0] mbb_r;

  kab_mac_ctl_t            mac_ctl;
  logic                    wb_en;
  logic                    div_start;
  logic signed [WordW-1:0] op_a;
  logic signed [WordW:0]   op_b;
  logic signed [WordW-1:0] addend;
  logic signed [FullW-1:0] sum_full;
  logic signed [WordW-1:0] sum_sat;
  logic                    div_done;
  logic signed [WordW-1:0] div_quo;
  logic signed [WordW-1:0] div_num;
  logic signed [WordW:0]   div_den;
  logic signed [WordW-1:0] dt_s;
  logic signed [WordW:0]   rate;
  logic                    in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ksel_nxt  = ksel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_MUL;
          op_nxt    = OP_ANGLE_PRED;
        end
      end
      ST_MUL: state_nxt = ST_WB;
      ST_WB: begin
        if (op_r == OP_P11) begin
          state_nxt = ST_ADD;
        end else if (op_r == OP_P00) begin
          state_nxt = ST_DSTART;
          ksel_nxt  = 1'b0;
        end else if (op_r == OP_COV_BB) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
          op_nxt    = kab_op_t'(op_r + 1'b1);
        end
      end
      ST_ADD: begin
        state_nxt = ST_MUL;
        op_nxt    = OP_P00;
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          if (ksel_r) begin
            state_nxt = ST_MUL;
            op_nxt    = OP_ANGLE_CORR;
          end else begin
            state_nxt = ST_DSTART;
            ksel_nxt  = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_ANGLE_PRED;
      ksel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ksel_r  <= ksel_nxt;
    end
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);
    wb_en        = (state_r == ST_WB);
    div_start    = (state_r == ST_DSTART);
    mac_ctl.load = (state_r == ST_MUL);
    mac_ctl.frac28 = (op_r >= OP_ANGLE_CORR);
    mac_ctl.neg    = (op_r >= OP_COV_AA);
  end

  // operand selection per step
  always_comb begin
    dt_s = $signed({8'd0, dt_r});
    rate = (WordW+1)'(gyro_r) - (WordW+1)'(bias_r);
    op_a   = dt_s;
    op_b   = '0;
    addend = '0;
    case (op_r)
      OP_ANGLE_PRED: begin op_b = rate; addend = angle_r; end
      OP_DT_BB:      begin op_b = (WordW+1)'(bb_r); end
      OP_P11:        begin op_b = $signed({2'd0, bn_r}); addend = bb_r; end
      OP_P00:        begin op_b = (WordW+1)'(inner_r); addend = aa_r; end
      OP_ANGLE_CORR: begin op_a = k0_r; op_b = (WordW+1)'(y_r); addend = angle_r; end
      OP_BIAS_CORR:  begin op_a = k1_r; op_b = (WordW+1)'(y_r); addend = bias_r; end
      OP_COV_AA:     begin op_a = k0_r; op_b = (WordW+1)'(p00_r); addend = p00_r; end
      OP_COV_AB:     begin op_a = k0_r; op_b = (WordW+1)'(p01_r); addend = p01_r; end
      OP_COV_BA:     begin op_a = k1_r; op_b = (WordW+1)'(p00_r); addend = p10_r; end
      OP_COV_BB:     begin op_a = k1_r; op_b = (WordW+1)'(p01_r); addend = p11_r; end
      default:       begin op_b = '0; end
    endcase
  end

  kab_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .op_a     (op_a),
    .op_b     (op_b),
    .addend   (addend),
    .sum_full (sum_full),
    .sum_sat  (sum_sat)
  );

  // gain division: innovation covariance S = P00 + measurement noise
  assign div_num = ksel_r ? p10_r : p00_r;
  assign div_den = (WordW+1)'(p00_r) + $signed({2'd0, mn_r});

  kab_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_r <= AngleNoiseRst;
      bn_r <= BiasNoiseRst;
      mn_r <= MeasureNoiseRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_NOISE:   an_r <= cfg_data;
        CFG_BIAS_NOISE:    bn_r <= cfg_data;
        CFG_MEASURE_NOISE: mn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= in_ch.measured_angle;
      gyro_r <= in_ch.gyro_rate;
      dt_r   <= in_ch.time_step;
    end
  end

  // filter state: estimates and covariance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      aa_r    <= '0;
      ab_r    <= '0;
      ba_r    <= '0;
      bb_r    <= '0;
    end else if (wb_en) begin
      case (op_r)
        OP_ANGLE_PRED: angle_r <= sum_sat;
        OP_ANGLE_CORR: angle_r <= sum_sat;
        OP_BIAS_CORR:  bias_r  <= sum_sat;
        OP_COV_AA:     aa_r    <= sum_sat;
        OP_COV_AB:     ab_r    <= sum_sat;
        OP_COV_BA:     ba_r    <= sum_sat;
        OP_COV_BB:     bb_r    <= sum_sat;
        default: ;
      endcase
    end
  end

  // predicted covariance, innovation and gains
  always_ff @(posedge clk) begin
    if (wb_en) begin
      case (op_r)
        OP_DT_BB: mbb_r <= sum_full;
        OP_P11:   p11_r <= sum_sat;
        OP_P00:   p00_r <= sum_sat;
        default: ;
      endcase
    end
    if (state_r == ST_ADD) begin
      inner_r <= sat32(mbb_r - FullW'(ab_r) - FullW'(ba_r) + $signed({17'd0, an_r}));
      p01_r   <= sat32(FullW'(ab_r) - mbb_r);
      p10_r   <= sat32(FullW'(ba_r) - mbb_r);
      y_r     <= sat32(FullW'(meas_r) - FullW'(angle_r));
    end
    if (div_done) begin
      if (ksel_r) k1_r <= div_quo;
      else        k0_r <= div_quo;
    end
  end

  assign out_ch.filtered_angle = angle_r;
  assign out_ch.rate_bias      = bias_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken while a sample is in flight");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DWAIT))
    else $error("divider result outside its wait state");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> in_ch.ready)
    else $error("not idle after result beat");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({in_ch.ready, out_ch.valid, mac_ctl.load}))
    else $error("sequencer drives overlapping phases");

endmodule
